FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the execute block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TRME_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define TRME_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/trme_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trme_pkg
// Types, codes and decode helpers of the register machine execute block.
// ---------------------------------------------------------------------------
package trme_pkg;

  typedef logic [15:0] word_t;
  typedef logic [7:0]  addr_t;
  typedef logic [2:0]  ridx_t;
  typedef logic [1:0]  rsel_t;

  typedef enum logic [2:0] {
    MODE_LOAD  = 3'd0,
    MODE_STORE = 3'd1,
    MODE_ADD   = 3'd2,
    MODE_SUB   = 3'd3,
    MODE_MUL   = 3'd4,
    MODE_JGT   = 3'd5,
    MODE_HALT  = 3'd6
  } mode_t;

  // load sub-modes
  localparam rsel_t LD_DIRECT   = 2'd0;
  localparam rsel_t LD_IMM      = 2'd1;
  localparam rsel_t LD_INDIRECT = 2'd2;
  localparam rsel_t LD_MOVE     = 2'd3;

  // store sub-modes at or above this use a register address
  localparam rsel_t ST_INDIRECT = 2'd2;

  localparam int RA_LSB  = 10;
  localparam int RB_LSB  = 8;
  localparam int IMM_LSB = 0;

  typedef struct packed {
    logic  rw;
    ridx_t ridx;
    word_t rval;
    logic  rd_en;
    addr_t rd_addr;
    logic  mw;
    addr_t waddr;
    word_t wdata;
    logic  jt;
    addr_t jtgt;
    logic  hl;
  } exec_t;

  // fixed register moves
  function automatic ridx_t move_dst(rsel_t ra);
    ridx_t d;
    case (ra)
      2'd0:    d = 3'd3;
      2'd1:    d = 3'd1;
      2'd2:    d = 3'd2;
      default: d = 3'd3;
    endcase
    return d;
  endfunction

  function automatic ridx_t move_src(rsel_t ra);
    return ridx_t'(ra) + 3'd1;
  endfunction

endpackage

FILE: rtl/trme_cmd_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trme_cmd_if
// Instruction channel: mode and low instruction bits.
// ---------------------------------------------------------------------------
interface trme_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [11:0] instruction_bits;

  modport source (output valid, output mode, output instruction_bits, input ready);
  modport sink   (input valid, input mode, input instruction_bits, output ready);
endinterface

FILE: rtl/trme_res_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trme_res_if
// Result channel: register, memory, jump and halt effects of one instruction.
// ---------------------------------------------------------------------------
interface trme_res_if;
  logic        valid;
  logic        ready;
  logic        reg_written;
  logic [2:0]  reg_index;
  logic [15:0] reg_value;
  logic        mem_written;
  logic [7:0]  mem_address;
  logic [15:0] mem_value;
  logic        jump_taken;
  logic [7:0]  jump_target;
  logic        halted;

  modport source (
    output valid, output reg_written, output reg_index, output reg_value,
    output mem_written, output mem_address, output mem_value,
    output jump_taken, output jump_target, output halted, input ready
  );
  modport sink (
    input valid, input reg_written, input reg_index, input reg_value,
    input mem_written, input mem_address, input mem_value,
    input jump_taken, input jump_target, input halted, output ready
  );
endinterface

FILE: rtl/tiny_register_machine_execute_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tiny_register_machine_execute_top
// Execute stage of a small 16-bit register machine.
// ---------------------------------------------------------------------------
// One instruction is taken per cycle while the pipeline advances, and its result
// passes through register read, execute with data memory read and writeback into
// the output register. Register file and data memory each have registered
// read ports; results are forwarded from the writeback stage and
// both memories read write-first, so dependent instructions issue back to
// back with no interlock. The pipeline advances whenever the output register
// is empty or its result is being taken. Both stores read as zero after reset
// through per-entry valid bits, so no clearing pass is needed.
`include "assert_macros.svh"

module tiny_register_machine_execute_top #(
  parameter int MEM_WORDS = 256,
  parameter int REG_COUNT = 5
) (
  input logic       clk,
  input logic       rst,
  trme_cmd_if.sink  cmd,
  trme_res_if.source res
);
  import trme_pkg::*;

  localparam int RIW = $clog2(REG_COUNT);
  localparam int MAW = $clog2(MEM_WORDS);

  logic  adv;
  logic  commit;

  rsel_t in_ra;
  rsel_t in_rb;
  ridx_t in_addr_a;

  logic       s1_valid;
  logic [2:0] s1_mode;
  rsel_t      s1_ra;
  rsel_t      s1_rb;
  addr_t      s1_imm;
  ridx_t      s1_addr_a;
  ridx_t      s1_addr_b;

  word_t rf_a;
  word_t rf_b;
  word_t op_a;
  word_t op_b;
  exec_t s1_exec;

  logic  s2_valid;
  exec_t s2;
  word_t dm_rdata;
  word_t s2_rval;

  assign adv       = !res.valid || res.ready;
  assign cmd.ready = adv;
  assign commit    = s2_valid && adv;

  assign in_ra     = cmd.instruction_bits[RA_LSB +: 2];
  assign in_rb     = cmd.instruction_bits[RB_LSB +: 2];
  assign in_addr_a = (cmd.mode == MODE_LOAD && in_rb == LD_MOVE) ? move_src(in_ra)
                                                                 : ridx_t'(in_ra);

  trme_regfile #(.DEPTH(REG_COUNT)) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .re      (adv),
    .raddr_a (RIW'(in_addr_a)),
    .raddr_b (RIW'(ridx_t'(in_rb))),
    .rdata_a (rf_a),
    .rdata_b (rf_b),
    .we      (commit && s2.rw),
    .waddr   (RIW'(s2.ridx)),
    .wdata   (s2_rval)
  );

  // bypass from writeback
  assign op_a = (s2_valid && s2.rw && s2.ridx == s1_addr_a) ? s2_rval : rf_a;
  assign op_b = (s2_valid && s2.rw && s2.ridx == s1_addr_b) ? s2_rval : rf_b;

  trme_alu u_alu (
    .mode (s1_mode),
    .ra   (s1_ra),
    .rb   (s1_rb),
    .imm  (s1_imm),
    .a    (op_a),
    .b    (op_b),
    .ex   (s1_exec)
  );

  trme_dmem #(.DEPTH(MEM_WORDS)) u_dmem (
    .clk   (clk),
    .rst   (rst),
    .re    (adv),
    .raddr (MAW'(s1_exec.rd_addr)),
    .rdata (dm_rdata),
    .we    (commit && s2.mw),
    .waddr (MAW'(s2.waddr)),
    .wdata (s2.wdata)
  );

  assign s2_rval = s2.rd_en ? dm_rdata : s2.rval;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= cmd.valid;
      s2_valid  <= s1_valid;
      res.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode   <= cmd.mode;
      s1_ra     <= in_ra;
      s1_rb     <= in_rb;
      s1_imm    <= cmd.instruction_bits[IMM_LSB +: 8];
      s1_addr_a <= in_addr_a;
      s1_addr_b <= ridx_t'(in_rb);
      s2        <= s1_exec;
      res.reg_written <= s2.rw;
      res.reg_index   <= s2.ridx;
      res.reg_value   <= s2_rval;
      res.mem_written <= s2.mw;
      res.mem_address <= s2.waddr;
      res.mem_value   <= s2.wdata;
      res.jump_taken  <= s2.jt;
      res.jump_target <= s2.jtgt;
      res.halted      <= s2.hl;
    end
  end

  `TRME_ASSERT_IMPL(a_single_effect, clk, rst, s2_valid, $countones({s2.rw, s2.mw, s2.jt, s2.hl}) <= 1)
  `TRME_ASSERT_NEXT(a_result_follows, clk, rst, s2_valid && adv, res.valid)
  `TRME_ASSERT_IMPL(a_reg_index_range, clk, rst, commit && s2.rw, s2.ridx < ridx_t'(REG_COUNT))

endmodule

FILE: rtl/trme_regfile.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trme_regfile
// Register file: two registered read ports, one write port, write-first.
// Entries read as zero until written after reset.
// ---------------------------------------------------------------------------
module trme_regfile #(
  parameter int DEPTH = 5,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                re,
  input  logic [IW-1:0]       raddr_a,
  input  logic [IW-1:0]       raddr_b,
  output trme_pkg::word_t     rdata_a,
  output trme_pkg::word_t     rdata_b,
  input  logic                we,
  input  logic [IW-1:0]       waddr,
  input  trme_pkg::word_t     wdata
);
  import trme_pkg::*;

  word_t            mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= (we && waddr == raddr_a) ? wdata : (vld[raddr_a] ? mem[raddr_a] : '0);
      rdata_b <= (we && waddr == raddr_b) ? wdata : (vld[raddr_b] ? mem[raddr_b] : '0);
    end
  end

endmodule

FILE: rtl/trme_dmem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trme_dmem
// Data memory: one registered read port, one write port, write-first.
// Words read as zero until written after reset.
// ---------------------------------------------------------------------------
module trme_dmem #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output trme_pkg::word_t rdata,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  trme_pkg::word_t wdata
);
  import trme_pkg::*;

  word_t            mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && waddr == raddr) ? wdata : (vld[raddr] ? mem[raddr] : '0);
    end
  end

endmodule

FILE: rtl/trme_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trme_alu
// Instruction decode and execute: arithmetic, compare, load/store addressing.
// ---------------------------------------------------------------------------
module trme_alu (
  input  logic [2:0]       mode,
  input  trme_pkg::rsel_t  ra,
  input  trme_pkg::rsel_t  rb,
  input  trme_pkg::addr_t  imm,
  input  trme_pkg::word_t  a,
  input  trme_pkg::word_t  b,
  output trme_pkg::exec_t  ex
);
  import trme_pkg::*;

  word_t prod;

  // low 16 bits of the product
  assign prod = a * b;

  always_comb begin
    ex = '0;
    case (mode_t'(mode))
      MODE_LOAD: begin
        ex.rw   = 1'b1;
        ex.ridx = ridx_t'(ra);
        case (rb)
          LD_DIRECT: begin
            ex.rd_en   = 1'b1;
            ex.rd_addr = imm;
          end
          LD_IMM: begin
            ex.rval = word_t'(imm);
          end
          LD_INDIRECT: begin
            ex.rd_en   = 1'b1;
            ex.rd_addr = b[7:0];
          end
          default: begin
            ex.ridx = move_dst(ra);
            ex.rval = a;
          end
        endcase
      end
      MODE_STORE: begin
        ex.mw    = 1'b1;
        ex.waddr = (rb < ST_INDIRECT) ? imm : b[7:0];
        ex.wdata = a;
      end
      MODE_ADD: begin
        ex.rw   = 1'b1;
        ex.ridx = ridx_t'(ra);
        ex.rval = a + b;
      end
      MODE_SUB: begin
        ex.rw   = 1'b1;
        ex.ridx = ridx_t'(ra);
        ex.rval = a - b;
      end
      MODE_MUL: begin
        ex.rw   = 1'b1;
        ex.ridx = ridx_t'(ra);
        ex.rval = prod;
      end
      MODE_JGT: begin
        if (a > b) begin
          ex.jt   = 1'b1;
          ex.jtgt = imm;
        end
      end
      MODE_HALT: begin
        ex.hl = 1'b1;
      end
      default: begin
        ex = '0;
      end
    endcase
  end

endmodule

FILE: bench/tiny_register_machine_execute_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tiny_register_machine_execute_top_test
// Drives instructions through the execute stage and checks every retired
// result against a local model of the register file and data memory. A
// directed opening covers each load and store sub-mode, the fixed moves,
// wrapping arithmetic, jump taken and not taken, and halt. Random traffic
// follows, with random idle on both channels, one long result back-pressure
// window, and one pause that waits for the pipeline to empty.
// ---------------------------------------------------------------------------
module tiny_register_machine_execute_top_test;
  import trme_pkg::*;

  localparam int MEM_WORDS    = 256;
  localparam int REG_COUNT    = 5;
  localparam int RANDOM_COUNT = 550;
  localparam int DRAIN_AT     = 350;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 200000;

  localparam ridx_t BASE_REG = 3'd2;
  localparam ridx_t MOVE_DST [4] = '{3'd3, 3'd1, 3'd2, 3'd3};
  localparam ridx_t MOVE_SRC [4] = '{3'd1, 3'd2, 3'd3, 3'd4};
  localparam addr_t ADDR_POOL [8] = '{8'h00, 8'h01, 8'h02, 8'h03,
                                      8'h7f, 8'h80, 8'hfe, 8'hff};

  typedef struct {
    mode_t       mode;
    logic [11:0] bits;
    bit          drain_first;
  } insn_t;

  typedef struct {
    logic  reg_written;
    ridx_t reg_index;
    word_t reg_value;
    logic  mem_written;
    addr_t mem_address;
    word_t mem_value;
    logic  jump_taken;
    addr_t jump_target;
    logic  halted;
  } retire_t;

  logic clk = 1'b0;
  logic rst;

  trme_cmd_if cmd_ch ();
  trme_res_if res_ch ();

  tiny_register_machine_execute_top dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  word_t   regs [REG_COUNT];
  word_t   data_mem [MEM_WORDS];
  insn_t   pending_insns [$];
  retire_t expected_retires [$];
  int      errors = 0;
  int      issued = 0;
  int      retired = 0;
  int      cycles = 0;
  int      send_gap = 0;
  int      recv_stall = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  logic    take_next;

  function automatic retire_t execute_insn(mode_t m, logic [11:0] bits);
    retire_t r;
    rsel_t   ra;
    rsel_t   rb;
    addr_t   imm;
    word_t   a;
    word_t   b;
    r = '{default: '0};
    ra = bits[11:10];
    rb = bits[9:8];
    imm = bits[7:0];
    a = regs[ra];
    b = regs[rb];
    case (m)
      MODE_LOAD: begin
        r.reg_written = 1'b1;
        r.reg_index = ridx_t'(ra);
        case (rb)
          LD_DIRECT:   r.reg_value = data_mem[imm];
          LD_IMM:      r.reg_value = {8'h00, imm};
          LD_INDIRECT: r.reg_value = data_mem[regs[BASE_REG][7:0]];
          default: begin
            r.reg_index = MOVE_DST[ra];
            r.reg_value = regs[MOVE_SRC[ra]];
          end
        endcase
      end
      MODE_STORE: begin
        r.mem_written = 1'b1;
        r.mem_address = (rb < ST_INDIRECT) ? imm : regs[rb][7:0];
        r.mem_value = a;
      end
      MODE_ADD, MODE_SUB, MODE_MUL: begin
        r.reg_written = 1'b1;
        r.reg_index = ridx_t'(ra);
        if (m == MODE_ADD) r.reg_value = a + b;
        else if (m == MODE_SUB) r.reg_value = a - b;
        else r.reg_value = a * b;
      end
      MODE_JGT: begin
        if (a > b) begin
          r.jump_taken = 1'b1;
          r.jump_target = imm;
        end
      end
      MODE_HALT: r.halted = 1'b1;
      default: ;
    endcase
    if (r.reg_written && r.reg_index < REG_COUNT) regs[r.reg_index] = r.reg_value;
    if (r.mem_written) data_mem[r.mem_address] = r.mem_value;
    return r;
  endfunction

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic insn_t random_insn();
    insn_t it;
    int    pick;
    rsel_t ra;
    rsel_t rb;
    addr_t imm;
    pick = $urandom_range(0, 99);
    ra = rsel_t'($urandom);
    rb = rsel_t'($urandom);
    imm = $urandom_range(0, 1) ? ADDR_POOL[$urandom_range(0, 7)] : addr_t'($urandom);
    if (pick < 30) it.mode = MODE_LOAD;
    else if (pick < 50) it.mode = MODE_STORE;
    else if (pick < 60) it.mode = MODE_ADD;
    else if (pick < 70) it.mode = MODE_SUB;
    else if (pick < 80) it.mode = MODE_MUL;
    else if (pick < 92) it.mode = MODE_JGT;
    else it.mode = MODE_HALT;
    it.bits = {ra, rb, imm};
    it.drain_first = 1'b0;
    return it;
  endfunction

  task automatic queue_insn(mode_t m, rsel_t ra, rsel_t rb, addr_t imm);
    insn_t it;
    it.mode = m;
    it.bits = {ra, rb, imm};
    it.drain_first = 1'b0;
    pending_insns.push_back(it);
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s at cycle %0d: got %h expected %h", what, cycles, got, want);
    errors++;
  endtask

  task automatic check_retire(retire_t got, retire_t want);
    if (got.reg_written !== want.reg_written)
      report_mismatch("reg_written", 16'(got.reg_written), 16'(want.reg_written));
    if (got.reg_index !== want.reg_index)
      report_mismatch("reg_index", 16'(got.reg_index), 16'(want.reg_index));
    if (got.reg_value !== want.reg_value)
      report_mismatch("reg_value", got.reg_value, want.reg_value);
    if (got.mem_written !== want.mem_written)
      report_mismatch("mem_written", 16'(got.mem_written), 16'(want.mem_written));
    if (got.mem_address !== want.mem_address)
      report_mismatch("mem_address", 16'(got.mem_address), 16'(want.mem_address));
    if (got.mem_value !== want.mem_value)
      report_mismatch("mem_value", got.mem_value, want.mem_value);
    if (got.jump_taken !== want.jump_taken)
      report_mismatch("jump_taken", 16'(got.jump_taken), 16'(want.jump_taken));
    if (got.jump_target !== want.jump_target)
      report_mismatch("jump_target", 16'(got.jump_target), 16'(want.jump_target));
    if (got.halted !== want.halted)
      report_mismatch("halted", 16'(got.halted), 16'(want.halted));
  endtask

  // instruction driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_retires.push_back(execute_insn(mode_t'(cmd_ch.mode),
                                                cmd_ch.instruction_bits));
        issued++;
      end
      if (!(cmd_ch.valid && !cmd_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_ch.valid <= 1'b0;
        end else if (pending_insns.size() > 0 &&
                     !(pending_insns[0].drain_first && expected_retires.size() > 0)) begin
          cmd_ch.valid <= 1'b1;
          cmd_ch.mode <= pending_insns[0].mode;
          cmd_ch.instruction_bits <= pending_insns[0].bits;
          void'(pending_insns.pop_front());
          // every fourth stretch of 64 transfers runs without idle
          send_gap = ((issued / 64) % 4 == 3) ? 0 : idle_len();
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      recv_stall = 0;
      hold_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_retires.size() == 0) begin
          report_mismatch("unexpected result", 16'h0, 16'h0);
        end else begin
          check_retire('{res_ch.reg_written, res_ch.reg_index, res_ch.reg_value,
                         res_ch.mem_written, res_ch.mem_address, res_ch.mem_value,
                         res_ch.jump_taken, res_ch.jump_target, res_ch.halted},
                       expected_retires.pop_front());
        end
        retired++;
      end
      if (!hold_done && retired >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        take_next = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        take_next = 1'b0;
      end else begin
        take_next = 1'b1;
        recv_stall = ((retired / 50) % 4 == 1) ? 0 : idle_len();
      end
      res_ch.ready <= take_next;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL tiny_register_machine_execute_top");
      $finish;
    end
  end

  initial begin
    insn_t it;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = MODE_HALT;
    cmd_ch.instruction_bits = '0;
    res_ch.ready = 1'b0;
    foreach (regs[i]) regs[i] = '0;
    foreach (data_mem[i]) data_mem[i] = '0;

    queue_insn(MODE_LOAD, 2'd0, LD_IMM, 8'hff);
    queue_insn(MODE_LOAD, 2'd1, LD_IMM, 8'h00);
    queue_insn(MODE_LOAD, 2'd2, LD_IMM, 8'h80);
    queue_insn(MODE_LOAD, 2'd3, LD_IMM, 8'h01);
    queue_insn(MODE_SUB, 2'd1, 2'd3, 8'h00);
    queue_insn(MODE_MUL, 2'd0, 2'd1, 8'hff);
    queue_insn(MODE_ADD, 2'd1, 2'd1, 8'h00);
    queue_insn(MODE_STORE, 2'd1, 2'd0, 8'hff);
    queue_insn(MODE_STORE, 2'd0, 2'd1, 8'h00);
    queue_insn(MODE_STORE, 2'd3, 2'd2, 8'h5a);
    queue_insn(MODE_STORE, 2'd1, 2'd3, 8'ha5);
    queue_insn(MODE_LOAD, 2'd3, LD_DIRECT, 8'hff);
    queue_insn(MODE_LOAD, 2'd0, LD_INDIRECT, 8'h00);
    queue_insn(MODE_LOAD, 2'd2, LD_DIRECT, 8'h7f);
    queue_insn(MODE_LOAD, 2'd0, LD_MOVE, 8'hff);
    queue_insn(MODE_LOAD, 2'd1, LD_MOVE, 8'h00);
    queue_insn(MODE_LOAD, 2'd2, LD_MOVE, 8'h3c);
    queue_insn(MODE_LOAD, 2'd3, LD_MOVE, 8'hc3);
    queue_insn(MODE_JGT, 2'd0, 2'd1, 8'hff);
    queue_insn(MODE_JGT, 2'd1, 2'd0, 8'h00);
    queue_insn(MODE_JGT, 2'd2, 2'd2, 8'haa);
    queue_insn(MODE_MUL, 2'd1, 2'd1, 8'h00);
    queue_insn(MODE_HALT, 2'd3, 2'd3, 8'hff);
    queue_insn(MODE_HALT, 2'd0, 2'd0, 8'h00);

    for (int n = 0; n < RANDOM_COUNT; n++) begin
      it = random_insn();
      if (n == DRAIN_AT) it.drain_first = 1'b1;
      pending_insns.push_back(it);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_insns.size() != 0 || cmd_ch.valid || expected_retires.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS tiny_register_machine_execute_top");
    end else begin
      $display("FAIL tiny_register_machine_execute_top");
    end
    $finish;
  end

endmodule
